// ----- rtl/flma_pkg.sv -----
// Shared widths and constants for the fuel level moving average.
`default_nettype none

package flma_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned LEVEL_W  = 7;

  localparam logic [SAMPLE_W-1:0] LEVEL_MAX    = 10'd100;
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 10'd100;

endpackage

`default_nettype wire

// ----- rtl/flma_ring.sv -----
// Sample ring: stores the last WINDOW samples and returns the one each write replaces.
`default_nettype none

module flma_ring
  import flma_pkg::*;
#(
  parameter int unsigned WINDOW = 512
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [SAMPLE_W-1:0] wr_data_i,
  output logic      [SAMPLE_W-1:0] old_data_o
);

  localparam int unsigned POS_W = $clog2(WINDOW);

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                filled_q, filled_d;
  logic                old_ok_q;

  always_comb begin
    pos_d    = pos_q;
    filled_d = filled_q;
    if (wr_en_i) begin
      if (pos_q == POS_W'(WINDOW - 1)) begin
        pos_d    = '0;
        filled_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      filled_q <= 1'b0;
      old_ok_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      filled_q <= filled_d;
      if (wr_en_i) begin
        old_ok_q <= filled_q;
      end
    end
  end

  // read-before-write: the slot's previous sample comes out registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_data_q  <= mem[pos_q];
      mem[pos_q] <= wr_data_i;
    end
  end

  // slots not yet written on the first lap read as zero
  assign old_data_o = old_ok_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/fuel_level_moving_average.sv -----
// Top level of the fuel level moving average over a ring of ADC samples.
// Usage:
//   s_axis carries one 10-bit fuel-sender ADC sample per request.
//   m_axis returns one result per sample: the fuel level (0..100) and the
//   truncated mean of the last WINDOW samples.
//   cfg_we_i/cfg_wdata_i write level_offset (the empty tank reading); write
//   it only while no request is in flight.
// Pipeline: four register stages (ring read, sum update, reciprocal multiply,
//   level compare), the first one loaded at the edge that accepts its sample.
// Throughput: one sample per cycle while m_axis takes results; the ring memory
//   has one read and one write port used once per sample.
// Reset: the sum, ring position and fill flag clear, level_offset returns to
//   100; ring slots not yet written on the first lap count as zero, so the
//   mean ramps up from zero.
// Stall: when m_axis is not ready the result holds; empty pipeline stages
//   still take new samples until all four stages are full.
`default_nettype none

module fuel_level_moving_average
  import flma_pkg::*;
#(
  parameter int unsigned WINDOW = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i,    // level_offset
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i, // [9:0] sample, [15:10] zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o  // [6:0] level, [16:7] average, [23:17] zero
);

  localparam int unsigned POS_W   = $clog2(WINDOW);
  localparam int unsigned SUM_W   = SAMPLE_W + POS_W;
  localparam int unsigned SHIFT   = SUM_W + POS_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [SAMPLE_W-1:0] offset_q;
  logic                v1_q, v2_q, v3_q, out_v_q;
  logic                en2, en3, en4, accept;
  logic [SAMPLE_W-1:0] smp_q, old_smp;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [PROD_W-1:0]   prod_q;
  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] diff;
  logic [LEVEL_W-1:0]  level_d, level_q;
  logic [SAMPLE_W-1:0] avg_q;

  assign en4             = !out_v_q || m_axis_tready_i;
  assign en3             = !v3_q || en4;
  assign en2             = !v2_q || en3;
  assign s_axis_tready_o = !v1_q || en2;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  flma_ring #(
    .WINDOW(WINDOW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (s_axis_tdata_i[SAMPLE_W-1:0]),
    .old_data_o(old_smp)
  );

  assign sum_d = sum_q - SUM_W'(old_smp) + SUM_W'(smp_q);

  assign avg  = prod_q[SHIFT +: SAMPLE_W];
  assign diff = offset_q - avg;

  always_comb begin
    if (avg > offset_q || diff > LEVEL_MAX) begin
      level_d = '0;
    end else begin
      level_d = diff[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      out_v_q  <= 1'b0;
      sum_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
        if (v1_q) begin
          sum_q <= sum_d;
        end
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        out_v_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (en3 && v2_q) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
    end
    if (en4 && v3_q) begin
      level_q <= level_d;
      avg_q   <= avg;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'd0, avg_q, level_q};

endmodule

`default_nettype wire

// ----- dv/flma_checker.sv -----
// Checker for the fuel level moving average: predicts each reading and compares results.
`default_nettype none

module flma_checker
  import flma_pkg::*;
#(
  parameter int unsigned WINDOW = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [15:0] s_data_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [23:0] m_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // low bits first: level, then average
  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [LEVEL_W-1:0]  level;
  } fuel_reading_t;

  logic [SAMPLE_W-1:0] ring [WINDOW];
  int unsigned         ring_sum;
  int unsigned         ring_pos;
  logic [SAMPLE_W-1:0] level_offset;
  fuel_reading_t       expected_readings_q [$];
  int                  fails = 0;

  assign fail_count_o = fails;

  function automatic fuel_reading_t take_sample(input logic [SAMPLE_W-1:0] smp);
    fuel_reading_t       rd;
    int unsigned         mean;
    logic [SAMPLE_W-1:0] diff;
    ring_sum = ring_sum - ring[ring_pos] + smp;
    ring[ring_pos] = smp;
    ring_pos = (ring_pos + 1 == WINDOW) ? 0 : ring_pos + 1;
    mean = ring_sum / WINDOW;
    rd.average = mean[SAMPLE_W-1:0];
    diff = level_offset - rd.average;
    // below zero or above full scale both read as empty
    if (rd.average > level_offset || diff > LEVEL_MAX) begin
      rd.level = '0;
    end else begin
      rd.level = diff[LEVEL_W-1:0];
    end
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
    fails++;
  endtask

  always @(posedge clk_i) begin : watch
    fuel_reading_t got;
    fuel_reading_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) ring[i] = '0;
      ring_sum = 0;
      ring_pos = 0;
      level_offset = OFFSET_RESET;
      expected_readings_q.delete();
    end else begin
      if (cfg_we_i) begin
        level_offset = cfg_wdata_i;
      end
      if (m_valid_i && m_ready_i) begin
        got = m_data_i[SAMPLE_W+LEVEL_W-1:0];
        if (expected_readings_q.size() == 0) begin
          report_mismatch("unrequested result", 32'd0, 32'(m_data_i));
        end else begin
          want = expected_readings_q.pop_front();
          if (got.level !== want.level) begin
            report_mismatch("level", 32'(want.level), 32'(got.level));
          end
          if (got.average !== want.average) begin
            report_mismatch("average", 32'(want.average), 32'(got.average));
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        expected_readings_q.push_back(take_sample(s_data_i[SAMPLE_W-1:0]));
      end
    end
    pending_o = expected_readings_q.size();
  end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Top of the fuel level moving average testbench: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top
  import flma_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 500000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [9:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  int          fail_count;
  int          pending;
  int          items_sent = 0;
  int          cycles = 0;

  always #5ns clk_i = ~clk_i;

  fuel_level_moving_average dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  flma_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_valid_i    (s_tvalid),
    .s_ready_i    (s_tready),
    .s_data_i     (s_tdata),
    .m_valid_i    (m_tvalid),
    .m_ready_i    (m_tready),
    .m_data_i     (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called and returns at a falling edge
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, smp};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // drain every outstanding request before touching the offset
  task automatic set_offset(input logic [SAMPLE_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : drain
    int r;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      m_tready <= 1'b1;
      if (r < 10) begin
        repeat ($urandom_range(100, 300)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      m_tready <= 1'b0;
      if (r >= 95) begin
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end else if (r >= 80) begin
        repeat ($urandom_range(4, 12)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] warmup [12];
    logic [SAMPLE_W-1:0] offset;
    int                  phase;
    int                  target;
    int                  spread;
    int                  len;
    int                  v;
    bit                  burst;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    warmup = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd512,
               10'd511, 10'd1022, 10'd1023, 10'd1023, 10'd1023, 10'd1023};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // startup fill at the reset offset
    foreach (warmup[i]) push_sample(warmup[i], pick_gap(i < 6));
    // mean above offset
    set_offset(10'd0);
    push_sample(10'd1023, 0);
    push_sample(10'd0, pick_gap(1'b0));
    push_sample(10'd700, 0);
    // difference above full scale
    set_offset(10'd1023);
    push_sample(10'd0, 0);
    push_sample(10'd1023, pick_gap(1'b0));
    push_sample(10'd300, 0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin offset = 10'd1023; target = 1023; spread = 0;  len = 600; end
        1: begin offset = 10'd0;    target = 0;    spread = 24; len = 80;  end
        2: begin offset = 10'd500;  target = 450;  spread = 24; len = 150; end
        3: begin offset = 10'd100;  target = 60;   spread = 24; len = 150; end
        default: begin
          offset = SAMPLE_W'($urandom_range(0, 1023));
          target = int'(offset) - int'($urandom_range(0, 130));
          if ($urandom_range(0, 9) == 0) target = int'($urandom_range(0, 1023));
          if (target < 0) target = 0;
          spread = int'($urandom_range(4, 40));
          len    = int'($urandom_range(60, 200));
        end
      endcase
      set_offset(offset);
      burst = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        if ($urandom_range(0, 99) < 12) begin
          v = int'($urandom_range(0, 1023));
        end else begin
          v = target + int'($urandom_range(0, 2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end
        push_sample(v[SAMPLE_W-1:0], pick_gap(burst));
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- fuel_level_moving_average.f -----
rtl/flma_pkg.sv
rtl/flma_ring.sv
rtl/fuel_level_moving_average.sv
dv/flma_checker.sv
dv/tb_top.sv
